### rtl/mmpcl_pkg.sv
`timescale 1ns / 1ps
package mmpcl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int OPND_W    = 34;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int ACC_W     = 56;
	localparam int PER_W     = 17;
	localparam int MODE_W    = 3;
	localparam int IDX_W     = 3;

	localparam logic [MODE_W-1:0] LAW_OPEN   = 3'd0;
	localparam logic [MODE_W-1:0] LAW_SPEED  = 3'd1;
	localparam logic [MODE_W-1:0] LAW_PI     = 3'd2;
	localparam logic [MODE_W-1:0] LAW_LEAD   = 3'd3;
	localparam logic [MODE_W-1:0] LAW_LL     = 3'd4;
	localparam logic [MODE_W-1:0] LAW_SFB    = 3'd5;
	localparam logic [MODE_W-1:0] LAW_SFB_I  = 3'd6;

	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD = 3'd1;
	localparam logic [IDX_W-1:0] REG_C0     = 3'd2;
	localparam logic [IDX_W-1:0] REG_C1     = 3'd3;
	localparam logic [IDX_W-1:0] REG_C2     = 3'd4;
	localparam logic [IDX_W-1:0] REG_C3     = 3'd5;
	localparam logic [IDX_W-1:0] REG_C4     = 3'd6;

	localparam logic signed [DATA_W-1:0] MAX_D = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN_D = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
		return (v > ACC_W'(MAX_D)) || (v < ACC_W'(MIN_D));
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > ACC_W'(MAX_D))
			return MAX_D;
		if (v < ACC_W'(MIN_D))
			return MIN_D;
		return v[DATA_W-1:0];
	endfunction

endpackage

### rtl/mmpcl_if.sv
`timescale 1ns / 1ps
interface mmpcl_in_if import mmpcl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [DATA_W-1:0] setpoint;
	logic [DATA_W-1:0] measured_position;
	logic [DATA_W-1:0] measured_speed;

	modport source (output valid, command, setpoint, measured_position, measured_speed,
		input ready);
	modport sink (input valid, command, setpoint, measured_position, measured_speed,
		output ready);
endinterface

interface mmpcl_out_if import mmpcl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] drive;
	logic              saturated;

	modport source (output valid, drive, saturated, input ready);
	modport sink (input valid, drive, saturated, output ready);
endinterface

### rtl/multi_mode_position_control_law.sv
`timescale 1ns / 1ps
// Sequence: open loop and clear items go from acceptance straight to the result register;
// other laws run N products in turn (N = 1, 4, 3, 5, 2, 4 for modes 1..6).
// Flow: one item at a time; the next item is taken only after the last has been fully
// worked on by the 34-step bit-serial multiplier and registered; a held result stalls it.
// Reset: arst_n clears configuration, history and handshake state at once; period = 655.
module multi_mode_position_control_law import mmpcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	mmpcl_in_if.sink          sample,
	mmpcl_out_if.source       result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_POST = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [5:0] MUL_LAST = 6'(OPND_W - 1);

	// configuration
	logic [MODE_W-1:0]        mode_q;
	logic [PER_W-1:0]         period_q;
	logic signed [DATA_W-1:0] c0_q, c1_q, c2_q, c3_q, c4_q;

	// history
	logic signed [DATA_W-1:0] pi_int_q, pil_q, e1_q, e2_q, d1_q, d2_q, si_q;

	// item being worked on
	logic signed [DATA_W-1:0] sp_q, pos_q, spd_q, e_q;
	logic                     clr_q;
	logic signed [OPND_W-2:0] tmp_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     flag_q;

	// sequencer and bit-serial multiplier
	logic [2:0]               state_q;
	logic [2:0]               op_q;
	logic [5:0]               cnt_q;
	logic signed [PROD_W-1:0] mcand_q, prod_q;
	logic signed [OPND_W-1:0] mplier_q;

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_drive_q;
	logic                     res_sat_q;

	logic [2:0]               nops;
	logic signed [OPND_W-1:0] sel_a, sel_b;
	logic                     sel_sh17, sel_neg, last_op;
	logic signed [ACC_W-1:0]  rnd, r_acc, drive_w;
	logic signed [DATA_W:0]   diff_e, diff_v;
	logic signed [PROD_W-1:0] addend;
	logic                     out_free;

	function automatic logic signed [OPND_W-1:0] x34(input logic signed [DATA_W-1:0] v);
		return {{(OPND_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic signed [ACC_W-1:0] x56(input logic signed [DATA_W-1:0] v);
		return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	assign sample.ready = (state_q == S_IDLE);
	assign out_free     = !res_valid_q || result.ready;

	// error terms saturate before use
	assign diff_e = {sample.setpoint[DATA_W-1], sample.setpoint}
		- {sample.measured_position[DATA_W-1], sample.measured_position};
	assign diff_v = {sp_q[DATA_W-1], sp_q} - {spd_q[DATA_W-1], spd_q};

	// product count per law
	always_comb begin
		unique case (mode_q)
			LAW_SPEED: nops = 3'd1;
			LAW_PI:    nops = 3'd4;
			LAW_LEAD:  nops = 3'd3;
			LAW_LL:    nops = 3'd5;
			LAW_SFB:   nops = 3'd2;
			LAW_SFB_I: nops = 3'd4;
			default:   nops = 3'd0;
		endcase
	end
	assign last_op = (op_q == nops - 3'd1);

	// operand selection for each product of each law
	always_comb begin
		sel_a    = x34(e_q);
		sel_b    = x34(c0_q);
		sel_sh17 = 1'b0;
		sel_neg  = 1'b0;
		case (mode_q)
			LAW_SPEED: sel_a = x34(sat32(ACC_W'(diff_v)));
			LAW_PI: begin
				case (op_q)
					3'd1: begin
						sel_a    = OPND_W'(tmp_q) + x34(pil_q);
						sel_b    = OPND_W'({1'b0, period_q});
						sel_sh17 = 1'b1;
					end
					3'd2: sel_b = x34(c1_q);
					3'd3: begin
						sel_a = OPND_W'(tmp_q);
						sel_b = x34(c2_q);
					end
					default: ;
				endcase
			end
			LAW_LEAD, LAW_LL: begin
				case (op_q)
					3'd1: begin
						sel_a = x34(e1_q);
						sel_b = x34(c1_q);
					end
					3'd2: begin
						sel_a   = (mode_q == LAW_LEAD) ? x34(d1_q) : x34(e2_q);
						sel_b   = x34(c2_q);
						sel_neg = (mode_q == LAW_LEAD);
					end
					3'd3: begin
						sel_a   = x34(d1_q);
						sel_b   = x34(c3_q);
						sel_neg = 1'b1;
					end
					3'd4: begin
						sel_a   = x34(d2_q);
						sel_b   = x34(c4_q);
						sel_neg = 1'b1;
					end
					default: ;
				endcase
			end
			LAW_SFB: begin
				if (op_q == 3'd1) begin
					sel_a   = x34(spd_q);
					sel_b   = x34(c1_q);
					sel_neg = 1'b1;
				end
			end
			LAW_SFB_I: begin
				case (op_q)
					3'd0: begin
						sel_a    = x34(e_q) + x34(e1_q);
						sel_b    = OPND_W'({1'b0, period_q});
						sel_sh17 = 1'b1;
					end
					3'd1: sel_a = x34(si_q);
					3'd2: begin
						sel_a   = x34(spd_q);
						sel_b   = x34(c2_q);
						sel_neg = 1'b1;
					end
					3'd3: begin
						sel_a   = x34(pos_q);
						sel_b   = x34(c1_q);
						sel_neg = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// round to nearest, ties up: add half then shift arithmetically
	always_comb begin
		logic signed [PROD_W-1:0] p;
		if (sel_sh17)
			p = (prod_q + (PROD_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
		else
			p = (prod_q + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		rnd = p[ACC_W-1:0];
	end
	assign r_acc   = sel_neg ? acc_q - rnd : acc_q + rnd;
	assign drive_w = acc_q;

	// sign bit of the multiplier carries negative weight
	assign addend = mplier_q[0] ? ((cnt_q == MUL_LAST) ? -mcand_q : mcand_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= LAW_OPEN;
			period_q <= PER_W'(655);
			c0_q     <= '0;
			c1_q     <= '0;
			c2_q     <= '0;
			c3_q     <= '0;
			c4_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:   mode_q   <= wr_data[MODE_W-1:0];
				REG_PERIOD: period_q <= wr_data[PER_W-1:0];
				REG_C0:     c0_q     <= wr_data;
				REG_C1:     c1_q     <= wr_data;
				REG_C2:     c2_q     <= wr_data;
				REG_C3:     c3_q     <= wr_data;
				REG_C4:     c4_q     <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			pi_int_q    <= '0;
			pil_q       <= '0;
			e1_q        <= '0;
			e2_q        <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			si_q        <= '0;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (result.ready && !(state_q == S_DONE && out_free))
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						// latch the item; open loop and clear need no products
						sp_q   <= sample.setpoint;
						pos_q  <= sample.measured_position;
						spd_q  <= sample.measured_speed;
						e_q    <= sat32(ACC_W'(diff_e));
						clr_q  <= sample.command;
						acc_q  <= '0;
						flag_q <= 1'b0;
						op_q   <= '0;
						state_q <= (sample.command || nops == 3'd0) ? S_DONE : S_LOAD;
					end
				end
				S_LOAD: begin
					mcand_q  <= PROD_W'(sel_a);
					mplier_q <= sel_b;
					prod_q   <= '0;
					cnt_q    <= '0;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					prod_q   <= prod_q + addend;
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >>> 1;
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST)
						state_q <= S_POST;
				end
				S_POST: begin
					if (mode_q == LAW_PI && op_q == 3'd0) begin
						tmp_q  <= (OPND_W-1)'(sat32(rnd));
						flag_q <= flag_q | ovf32(rnd);
					end else if (mode_q == LAW_PI && op_q == 3'd1) begin
						pi_int_q <= sat32(x56(pi_int_q) + rnd);
						flag_q   <= flag_q | ovf32(x56(pi_int_q) + rnd);
						pil_q    <= tmp_q[DATA_W-1:0];
					end else if (mode_q == LAW_PI && op_q == 3'd2) begin
						tmp_q  <= (OPND_W-1)'(sat32(rnd + x56(pi_int_q) - x56(spd_q)));
						flag_q <= flag_q | ovf32(rnd + x56(pi_int_q) - x56(spd_q));
					end else if (mode_q == LAW_SFB_I && op_q == 3'd0) begin
						si_q   <= sat32(x56(si_q) + rnd);
						flag_q <= flag_q | ovf32(x56(si_q) + rnd);
					end else begin
						acc_q <= r_acc;
					end
					op_q    <= op_q + 3'd1;
					state_q <= last_op ? S_DONE : S_LOAD;
				end
				S_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (clr_q) begin
							// clear: zero all history, drive nothing
							res_drive_q <= '0;
							res_sat_q   <= 1'b0;
							pi_int_q    <= '0;
							pil_q       <= '0;
							e1_q        <= '0;
							e2_q        <= '0;
							d1_q        <= '0;
							d2_q        <= '0;
							si_q        <= '0;
						end else if (nops == 3'd0) begin
							res_drive_q <= sp_q;
							res_sat_q   <= 1'b0;
						end else begin
							res_drive_q <= sat32(drive_w);
							res_sat_q   <= flag_q | ovf32(drive_w);
							// advance the compensator histories
							if (mode_q == LAW_LEAD) begin
								d1_q <= sat32(drive_w);
								e1_q <= e_q;
							end else if (mode_q == LAW_LL) begin
								d2_q <= d1_q;
								d1_q <= sat32(drive_w);
								e2_q <= e1_q;
								e1_q <= e_q;
							end else if (mode_q == LAW_SFB_I) begin
								e1_q <= e_q;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid     = res_valid_q;
	assign result.drive     = res_drive_q;
	assign result.saturated = res_sat_q;

	// the multiplier never runs past the sign step
	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q <= MUL_LAST)
		else $error("multiplier step count overrun");

	// a product is only loaded for a law that has one at that position
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> op_q < nops)
		else $error("product index beyond law");

	// a finished item always reaches the output register
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (result.valid && state_q == S_IDLE))
		else $error("finished item not delivered");

endmodule
